// File: rtl/ccp_pkg.sv
// Shared types, codes and signature constants for the cartridge image parser.
// No dependencies; used by every module of the block.
package ccp_pkg;

  localparam int IMAGE_SIZE_BITS = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Image signatures, first byte in the top bits.
  localparam logic [127:0] SIG_FIRST  = 128'h43363420434152545249444745202020;
  localparam logic [127:0] SIG_SECOND = 128'h56494332302043415254524944474520;
  localparam logic [31:0]  SIG_CHIP   = 32'h43484950;

  localparam int HEADER_BYTES = 64;
  localparam int PACKET_BYTES = 16;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_CHIP   = 2'd1,
    KIND_ROM    = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SIG     = 3'd1,
    ST_BAD_LENGTH  = 3'd2,
    ST_ROM_TOO_BIG = 3'd3,
    ST_NO_CHIP_SIG = 3'd4,
    ST_EXHAUSTED   = 3'd5,
    ST_SHORT_FILE  = 3'd6
  } status_t;

  // Work for one input byte: an optional primary result and an optional end result.
  typedef struct packed {
    logic        has_first;
    kind_t       kind;
    logic [16:0] header_flags;
    logic [15:0] format_version;
    logic [15:0] hw_word;
    logic [15:0] chip_code;
    logic [15:0] bank_index;
    logic [15:0] load_base;
    logic [15:0] rom_count;
    logic [7:0]  rom_byte;
    logic [19:0] chip_count;
    logic        has_end;
    status_t     end_status;
  } cmd_t;

  function automatic logic [7:0] sig_byte(input logic [127:0] sig, input logic [3:0] idx);
    logic [127:0] sh;
    sh = sig << {idx, 3'b000};
    return sh[127:120];
  endfunction

  function automatic logic [7:0] chip_sig_byte(input logic [1:0] idx);
    logic [31:0] sh;
    sh = SIG_CHIP << {idx, 3'b000};
    return sh[31:24];
  endfunction

endpackage

// File: rtl/cartridge_image_chip_parser.sv
// Cartridge image parser top level: byte input channel, result output channel.
// Path: a byte's command is written into the command queue and then loaded into the back-end
// result register, from which its result is offered.
// Throughput: one byte per cycle while the queue is not full; a byte with two results needs
// two transfers; the four-entry queue absorbs that and any output stall before input stalls.
// Reset (rst, synchronous) returns the parse to the header phase and clears the image size.
// Depends on ccp_pkg, ccp_front, ccp_queue and ccp_back.
module cartridge_image_chip_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ccp_pkg::IMAGE_SIZE_BITS-1:0] cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          data_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          result_kind,
  output logic [2:0]                          status,
  output logic [16:0]                         header_flags,
  output logic [15:0]                         format_version,
  output logic [15:0]                         hw_word,
  output logic [15:0]                         chip_code,
  output logic [15:0]                         bank_index,
  output logic [15:0]                         load_base,
  output logic [15:0]                         rom_count,
  output logic [7:0]                          rom_byte,
  output logic [19:0]                         chip_count,
  output logic                                last_of_run
);
  import ccp_pkg::*;

  cmd_t  f_cmd, q_cmd;
  kind_t kind;
  logic  f_push, q_full, q_not_empty, q_pop;

  // Input is taken whenever the queue has room for the command of one byte.
  assign in_ready = ~q_full;

  ccp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (in_valid & in_ready),
    .data_byte (data_byte),
    .push      (f_push),
    .cmd       (f_cmd)
  );

  ccp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .wr_cmd    (f_cmd),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .rd_cmd    (q_cmd)
  );

  // The back end offers each result transfer in order, the end result last.
  ccp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (kind),
    .status         (status),
    .header_flags   (header_flags),
    .format_version (format_version),
    .hw_word        (hw_word),
    .chip_code      (chip_code),
    .bank_index     (bank_index),
    .load_base      (load_base),
    .rom_count      (rom_count),
    .rom_byte       (rom_byte),
    .chip_count     (chip_count),
    .last_of_run    (last_of_run)
  );

  assign result_kind = kind;
endmodule

// File: rtl/ccp_front.sv
// Front part: accepts image bytes, runs the parse state and builds a command for each byte that yields a result.
// Depends on ccp_pkg.
module ccp_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ccp_pkg::IMAGE_SIZE_BITS-1:0]  cfg_wdata,
  input  logic                                 take,
  input  logic [7:0]                           data_byte,
  output logic                                 push,
  output ccp_pkg::cmd_t                        cmd
);
  import ccp_pkg::*;

  localparam int FW = IMAGE_SIZE_BITS;
  localparam int OW = FW + 10;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_SKIP   = 6'b000010,
    PH_CHIP   = 6'b000100,
    PH_ROM    = 6'b001000,
    PH_PAD    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  phase_t        phase, phase_next;
  logic [FW-1:0] image_size;
  logic [FW-1:0] pos, pos_next;
  logic [1:0]    sig, sig_next;
  logic [31:0]   hlen, hlen_next;
  logic [47:0]   hwords, hwords_next;
  logic [FW-1:0] pkt_start, pkt_start_next;
  logic [31:0]   pkt_len, pkt_len_next;
  logic [63:0]   pkt_words, pkt_words_next;
  logic [3:0]    chip_idx, chip_idx_next;
  logic [15:0]   rom_left, rom_left_next;
  logic [19:0]   chips, chips_next;
  logic [OW-1:0] pkt_end, pkt_end16;

  logic          want_next, want_finish;
  logic [OW-1:0] off, off16, fs_w, pos_w;
  logic [OW-1:0] hoff;
  logic [15:0]   rom;

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    sig_next       = sig;
    hlen_next      = hlen;
    hwords_next    = hwords;
    pkt_start_next = pkt_start;
    pkt_len_next   = pkt_len;
    pkt_words_next = pkt_words;
    chip_idx_next  = chip_idx;
    rom_left_next  = rom_left;
    chips_next     = chips;
    want_next      = 1'b0;
    want_finish    = 1'b0;
    off            = '0;
    off16          = '0;
    hoff           = '0;
    rom            = '0;
    cmd            = '0;
    push           = 1'b0;
    fs_w           = OW'(image_size);
    pos_w          = OW'(pos) + OW'(1);

    if (take && phase != PH_DONE && pos < image_size) begin
      pos_next = pos + FW'(1);
      unique case (phase)
        PH_HEADER: begin
          if (pos < FW'(16)) begin
            if (data_byte != sig_byte(SIG_FIRST, pos[3:0]))  sig_next[0] = 1'b0;
            if (data_byte != sig_byte(SIG_SECOND, pos[3:0])) sig_next[1] = 1'b0;
          end else if (pos < FW'(20)) begin
            hlen_next = {hlen[23:0], data_byte};
          end else if (pos < FW'(26)) begin
            hwords_next = {hwords[39:0], data_byte};
          end
          if (image_size < FW'(HEADER_BYTES) && pos_w == fs_w) begin
            cmd.has_end    = 1'b1;
            cmd.end_status = ST_SHORT_FILE;
          end else if (pos == FW'(HEADER_BYTES - 1)) begin
            if (sig_next == 2'b00) begin
              cmd.has_end    = 1'b1;
              cmd.end_status = ST_BAD_SIG;
            end else begin
              cmd.has_first      = 1'b1;
              cmd.kind           = KIND_HEADER;
              cmd.header_flags   = {~sig_next[0], hwords_next[15:0]};
              cmd.format_version = hwords_next[47:32];
              cmd.hw_word        = hwords_next[31:16];
              hoff = (hlen_next < 32'(HEADER_BYTES)) ? OW'(HEADER_BYTES) : OW'(hlen_next);
              want_next = 1'b1;
              off   = hoff;
              off16 = hoff + OW'(PACKET_BYTES);
            end
          end
        end
        PH_SKIP: begin
          if (pos_next == pkt_start) phase_next = PH_CHIP;
        end
        PH_CHIP: begin
          chip_idx_next = chip_idx + 4'd1;
          if (chip_idx < 4'd4) begin
            if (data_byte != chip_sig_byte(chip_idx[1:0])) sig_next = 2'b00;
          end else if (chip_idx < 4'd8) begin
            pkt_len_next = {pkt_len[23:0], data_byte};
          end else begin
            pkt_words_next = {pkt_words[55:0], data_byte};
          end
          if (chip_idx == 4'd15) begin
            rom = pkt_words_next[15:0];
            if (sig == 2'b00) begin
              cmd.has_end    = 1'b1;
              cmd.end_status = ST_NO_CHIP_SIG;
            end else if (pkt_len < 32'(PACKET_BYTES) || pkt_end > fs_w) begin
              cmd.has_end    = 1'b1;
              cmd.end_status = ST_BAD_LENGTH;
            end else if (33'(rom) + 33'(PACKET_BYTES) > 33'(pkt_len)) begin
              cmd.has_end    = 1'b1;
              cmd.end_status = ST_ROM_TOO_BIG;
            end else begin
              chips_next     = chips + 20'd1;
              cmd.has_first  = 1'b1;
              cmd.kind       = KIND_CHIP;
              cmd.chip_code  = pkt_words_next[63:48];
              cmd.bank_index = pkt_words_next[47:32];
              cmd.load_base  = pkt_words_next[31:16];
              cmd.rom_count  = rom;
              rom_left_next  = rom;
              if (rom != 16'd0) phase_next = PH_ROM;
              else              want_finish = 1'b1;
            end
          end
        end
        PH_ROM: begin
          cmd.has_first = 1'b1;
          cmd.kind      = KIND_ROM;
          cmd.rom_byte  = data_byte;
          rom_left_next = rom_left - 16'd1;
          if (rom_left_next == 16'd0) want_finish = 1'b1;
        end
        PH_PAD: begin
          want_finish = 1'b1;
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase

      if (want_finish) begin
        if (pos_w >= pkt_end) begin
          want_next = 1'b1;
          off   = pkt_end;
          off16 = pkt_end16;
        end else begin
          phase_next = PH_PAD;
        end
      end

      if (want_next) begin
        if (off16 > fs_w) begin
          cmd.has_end    = 1'b1;
          cmd.end_status = (off > fs_w) ? ST_SHORT_FILE :
                           ((off == fs_w) ? ST_OK : ST_EXHAUSTED);
        end else begin
          pkt_start_next = off[FW-1:0];
          pkt_len_next   = '0;
          pkt_words_next = '0;
          chip_idx_next  = '0;
          sig_next       = 2'b01;
          phase_next     = (pos_w == off) ? PH_CHIP : PH_SKIP;
        end
      end

      if (cmd.has_end) phase_next = PH_DONE;
      cmd.chip_count = chips_next;
      push = cmd.has_first | cmd.has_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      image_size <= '0;
      pos        <= '0;
      sig        <= 2'b11;
      hlen       <= '0;
      hwords     <= '0;
      pkt_start  <= '0;
      pkt_len    <= '0;
      pkt_words  <= '0;
      chip_idx   <= '0;
      rom_left   <= '0;
      chips      <= '0;
    end else begin
      phase      <= phase_next;
      pos        <= pos_next;
      sig        <= sig_next;
      hlen       <= hlen_next;
      hwords     <= hwords_next;
      pkt_start  <= pkt_start_next;
      pkt_len    <= pkt_len_next;
      pkt_words  <= pkt_words_next;
      chip_idx   <= chip_idx_next;
      rom_left   <= rom_left_next;
      chips      <= chips_next;
      if (cfg_we) image_size <= cfg_wdata;
    end
  end

  // Packet end is registered from the packet start and length; it is read only from the last packet
  // header byte on, long after the length bytes have settled.
  always_ff @(posedge clk) begin
    pkt_end   <= OW'(pkt_start) + OW'(pkt_len);
    pkt_end16 <= OW'(pkt_start) + OW'(pkt_len) + OW'(PACKET_BYTES);
  end

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE)
    else $error("parser left the done phase");

  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    push && cmd.has_end |=> phase == PH_DONE)
    else $error("end result issued without stopping the parse");
endmodule

// File: rtl/ccp_queue.sv
// Short command queue between the parser front and the result back end.
// Depends on ccp_pkg.
module ccp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ccp_pkg::cmd_t wr_cmd,
  output logic          full,
  output logic          not_empty,
  input  logic          pop,
  output ccp_pkg::cmd_t rd_cmd
);
  import ccp_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("command queue underflow");
endmodule

// File: rtl/ccp_back.sv
// Back end: takes commands from the queue and presents one or two results each.
// Depends on ccp_pkg.
module ccp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_not_empty,
  input  ccp_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output ccp_pkg::kind_t result_kind,
  output logic [2:0]    status,
  output logic [16:0]   header_flags,
  output logic [15:0]   format_version,
  output logic [15:0]   hw_word,
  output logic [15:0]   chip_code,
  output logic [15:0]   bank_index,
  output logic [15:0]   load_base,
  output logic [15:0]   rom_count,
  output logic [7:0]    rom_byte,
  output logic [19:0]   chip_count,
  output logic          last_of_run
);
  import ccp_pkg::*;

  cmd_t cur;
  logic busy, on_end;
  logic show_end, done_cur, xfer;

  assign show_end = on_end | ~cur.has_first;
  assign xfer     = busy & out_ready;
  assign done_cur = show_end | ~cur.has_end;
  assign q_pop    = q_not_empty & (~busy | (xfer & done_cur));
  assign out_valid = busy;

  always_comb begin
    result_kind    = show_end ? KIND_END : cur.kind;
    status         = show_end ? cur.end_status : ST_OK;
    header_flags   = show_end ? '0 : cur.header_flags;
    format_version = show_end ? '0 : cur.format_version;
    hw_word        = show_end ? '0 : cur.hw_word;
    chip_code      = show_end ? '0 : cur.chip_code;
    bank_index     = show_end ? '0 : cur.bank_index;
    load_base      = show_end ? '0 : cur.load_base;
    rom_count      = show_end ? '0 : cur.rom_count;
    rom_byte       = show_end ? '0 : cur.rom_byte;
    chip_count     = (!show_end && cur.kind == KIND_HEADER) ? '0 : cur.chip_count;
    last_of_run    = done_cur;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      on_end <= 1'b0;
    end else if (q_pop) begin
      busy   <= 1'b1;
      on_end <= 1'b0;
    end else if (xfer) begin
      if (done_cur) begin
        busy <= 1'b0;
      end else begin
        on_end <= 1'b1;
      end
    end
  end

  a_end_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    busy && on_end |-> cur.has_end && cur.has_first)
    else $error("end result shown for a command without one");
endmodule
